// ===== rtl/core/mke_pkg.sv =====
// Shared types, constants and the character decode table for the Morse keyer.
// Used by mke_queue, mke_keyer and morse_keyer_envelope_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mke_pkg;

	// Character queue geometry.
	localparam int QUEUE_DEPTH = 64;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Field widths.
	localparam int UNIT_W = 20;
	localparam int LEN_W  = 23;
	localparam int LVL_W  = 16;
	localparam int CFG_W  = 20;

	// Reset values of the configuration registers.
	localparam logic [UNIT_W-1:0] UNIT_RST  = UNIT_W'(1440);
	localparam logic [LVL_W-1:0]  RAMP_RST  = LVL_W'(273);
	localparam logic [LVL_W-1:0]  PHASE_RST = LVL_W'(820);

	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_UNIT_SAMPLES = 2'd0,
		REG_RAMP_STEP    = 2'd1,
		REG_PHASE_STEP   = 2'd2,
		REG_MUTE         = 2'd3
	} reg_idx_t;

	// Kind of the symbol being played.
	typedef enum logic [2:0] {
		KIND_IDLE     = 3'd0,
		KIND_DIT      = 3'd1,
		KIND_DAH      = 3'd2,
		KIND_ELEM_GAP = 3'd3,
		KIND_CHAR_GAP = 3'd4,
		KIND_WORD_GAP = 3'd5
	} kind_t;

	// One queue entry, decoded at enqueue time.
	typedef struct packed {
		logic       is_space;
		logic       known;
		logic [2:0] len;
		logic [5:0] pat;
		logic [7:0] ch;
	} qent_t;

	// Queue status seen by the keyer.
	typedef struct packed {
		logic nonempty;
		logic full;
	} qstat_t;

	// Timing configuration with the derived unit multiples.
	typedef struct packed {
		logic [UNIT_W-1:0] unit;
		logic [LEN_W-1:0]  unit3;
		logic [LEN_W-1:0]  unit7;
		logic [LVL_W-1:0]  ramp_step;
		logic [LVL_W-1:0]  phase_step;
	} cfg_t;

	// One result.
	typedef struct packed {
		logic             key_down;
		logic [LVL_W-1:0] envelope;
		logic [LVL_W-1:0] tone_phase;
		logic             char_start;
		logic [7:0]       char_sent;
		logic             idle_start;
		logic             dropped;
	} res_t;

	// Uppercase a character and look up its dit/dah pattern.
	// Pattern bit i set means element i (first sent is bit 0) is a dah.
	function automatic qent_t decode_char(input logic [7:0] c);
		qent_t      e;
		logic [7:0] u;
		u = c;
		if (c inside {[8'h61:8'h7A]}) begin
			u = c - 8'h20;
		end
		e.is_space = (c == CHAR_SPACE);
		e.known    = 1'b1;
		e.ch       = u;
		e.len      = 3'd0;
		e.pat      = 6'h00;
		case (u)
			8'h41: begin e.len = 3'd2; e.pat = 6'h02; end // A
			8'h42: begin e.len = 3'd4; e.pat = 6'h01; end // B
			8'h43: begin e.len = 3'd4; e.pat = 6'h05; end // C
			8'h44: begin e.len = 3'd3; e.pat = 6'h01; end // D
			8'h45: begin e.len = 3'd1; e.pat = 6'h00; end // E
			8'h46: begin e.len = 3'd4; e.pat = 6'h04; end // F
			8'h47: begin e.len = 3'd3; e.pat = 6'h03; end // G
			8'h48: begin e.len = 3'd4; e.pat = 6'h00; end // H
			8'h49: begin e.len = 3'd2; e.pat = 6'h00; end // I
			8'h4A: begin e.len = 3'd4; e.pat = 6'h0E; end // J
			8'h4B: begin e.len = 3'd3; e.pat = 6'h05; end // K
			8'h4C: begin e.len = 3'd4; e.pat = 6'h02; end // L
			8'h4D: begin e.len = 3'd2; e.pat = 6'h03; end // M
			8'h4E: begin e.len = 3'd2; e.pat = 6'h01; end // N
			8'h4F: begin e.len = 3'd3; e.pat = 6'h07; end // O
			8'h50: begin e.len = 3'd4; e.pat = 6'h06; end // P
			8'h51: begin e.len = 3'd4; e.pat = 6'h0B; end // Q
			8'h52: begin e.len = 3'd3; e.pat = 6'h02; end // R
			8'h53: begin e.len = 3'd3; e.pat = 6'h00; end // S
			8'h54: begin e.len = 3'd1; e.pat = 6'h01; end // T
			8'h55: begin e.len = 3'd3; e.pat = 6'h04; end // U
			8'h56: begin e.len = 3'd4; e.pat = 6'h08; end // V
			8'h57: begin e.len = 3'd3; e.pat = 6'h06; end // W
			8'h58: begin e.len = 3'd4; e.pat = 6'h09; end // X
			8'h59: begin e.len = 3'd4; e.pat = 6'h0D; end // Y
			8'h5A: begin e.len = 3'd4; e.pat = 6'h03; end // Z
			8'h30: begin e.len = 3'd5; e.pat = 6'h1F; end // 0
			8'h31: begin e.len = 3'd5; e.pat = 6'h1E; end // 1
			8'h32: begin e.len = 3'd5; e.pat = 6'h1C; end // 2
			8'h33: begin e.len = 3'd5; e.pat = 6'h18; end // 3
			8'h34: begin e.len = 3'd5; e.pat = 6'h10; end // 4
			8'h35: begin e.len = 3'd5; e.pat = 6'h00; end // 5
			8'h36: begin e.len = 3'd5; e.pat = 6'h01; end // 6
			8'h37: begin e.len = 3'd5; e.pat = 6'h03; end // 7
			8'h38: begin e.len = 3'd5; e.pat = 6'h07; end // 8
			8'h39: begin e.len = 3'd5; e.pat = 6'h0F; end // 9
			8'h2E: begin e.len = 3'd6; e.pat = 6'h2A; end // full stop
			8'h2C: begin e.len = 3'd6; e.pat = 6'h33; end // comma
			8'h3F: begin e.len = 3'd6; e.pat = 6'h0C; end // question mark
			8'h2F: begin e.len = 3'd5; e.pat = 6'h09; end // slash
			8'h3D: begin e.len = 3'd5; e.pat = 6'h11; end // equals
			8'h2B: begin e.len = 3'd5; e.pat = 6'h0A; end // plus
			8'h2D: begin e.len = 3'd6; e.pat = 6'h21; end // hyphen
			default: begin e.known = 1'b0; end
		endcase
		return e;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mke_queue.sv =====
// Character queue: decoded entries in a synchronous memory with a look-ahead head register.
// Depends on mke_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mke_queue (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [7:0]       push_char,
	input  wire              pop,
	output mke_pkg::qent_t   head,
	output mke_pkg::qstat_t  qstat
);
	import mke_pkg::*;

	qent_t            mem_q [QUEUE_DEPTH];
	qent_t            head_q;
	qent_t            wdata;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_inc;
	logic [PTR_W-1:0] wr_ptr_inc;
	logic [PTR_W-1:0] rd_addr;
	logic [CNT_W-1:0] count_q;
	logic             full;
	logic             wr;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign wr    = push && !full;
	assign wdata = decode_char(push_char);

	// Pointer increments wrap at the queue depth.
	assign rd_ptr_inc = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
	assign wr_ptr_inc = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);

	// Read ahead at the pointer that will be the head after this edge.
	assign rd_addr = pop ? rd_ptr_inc : rd_ptr_q;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_inc;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_inc;
			end
			if (wr && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Memory write, and registered read with forwarding of a write to the entry being read.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
		if (wr && (wr_ptr_q == rd_addr)) begin
			head_q <= wdata;
		end else begin
			head_q <= mem_q[rd_addr];
		end
	end

	assign head           = head_q;
	assign qstat.nonempty = (count_q != '0);
	assign qstat.full     = full;

endmodule

`default_nettype wire

// ===== rtl/core/mke_keyer.sv =====
// Symbol sequencer, envelope ramp and tone phase accumulator, advanced once per tick.
// Depends on mke_pkg; takes its characters from mke_queue.
`timescale 1ns / 1ps
`default_nettype none

module mke_keyer (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              tick,
	input  mke_pkg::cfg_t    cfg,
	input  mke_pkg::qent_t   head,
	input  mke_pkg::qstat_t  qstat,
	output logic             pop,
	output mke_pkg::res_t    res
);
	import mke_pkg::*;

	logic [5:0]       code_pattern_q;
	logic [2:0]       code_length_q;
	logic [3:0]       symbol_index_q;
	kind_t            symbol_kind_q;
	logic [LEN_W-1:0] symbol_length_q;
	logic [LEN_W-1:0] sample_count_q;
	logic [LVL_W-1:0] envelope_q;
	logic [LVL_W-1:0] phase_q;

	logic             fetch;
	logic             exhausted;
	logic             pop_c;
	logic             cs;
	logic [7:0]       sent;
	logic             idle;
	logic [5:0]       pat_n;
	logic [2:0]       len_n;
	logic [3:0]       idx_n;
	logic [3:0]       idx_inc;
	logic [7:0]       pat_ext;
	kind_t            kind_n;
	logic [LEN_W-1:0] kind_len;
	logic [LEN_W-1:0] slen_n;
	logic [LEN_W-1:0] sc_inc;
	logic [LEN_W-1:0] sc_n;
	logic             key;
	logic [LVL_W:0]   env_sum;
	logic [LVL_W-1:0] env_n;
	logic [LVL_W-1:0] ph_n;

	assign fetch     = (sample_count_q == '0);
	assign exhausted = (symbol_index_q >= {code_length_q, 1'b0});
	assign idx_inc   = symbol_index_q + 4'd1;
	assign pat_ext   = {2'b00, code_pattern_q};

	// Next symbol: a new character from the queue, or the next element or gap of this one.
	always_comb begin
		pop_c  = 1'b0;
		cs     = 1'b0;
		sent   = 8'h00;
		idle   = 1'b0;
		len_n  = code_length_q;
		pat_n  = code_pattern_q;
		idx_n  = symbol_index_q;
		kind_n = symbol_kind_q;
		if (fetch) begin
			if (exhausted) begin
				len_n  = 3'd0;
				pat_n  = 6'h00;
				idx_n  = 4'd1;
				kind_n = KIND_IDLE;
				if (qstat.nonempty) begin
					pop_c = 1'b1;
					if (head.is_space) begin
						kind_n = KIND_WORD_GAP;
						cs     = 1'b1;
						sent   = head.ch;
					end else if (head.known) begin
						len_n  = head.len;
						pat_n  = head.pat;
						cs     = 1'b1;
						sent   = head.ch;
						kind_n = head.pat[0] ? KIND_DAH : KIND_DIT;
					end
				end else begin
					idle = 1'b1;
				end
			end else begin
				idx_n = idx_inc;
				if (symbol_index_q[0]) begin
					kind_n = (idx_inc == {code_length_q, 1'b0}) ? KIND_CHAR_GAP : KIND_ELEM_GAP;
				end else begin
					kind_n = pat_ext[symbol_index_q[3:1]] ? KIND_DAH : KIND_DIT;
				end
			end
		end
	end

	// Length of the symbol in samples.
	always_comb begin
		case (kind_n)
			KIND_DAH, KIND_CHAR_GAP: kind_len = cfg.unit3;
			KIND_WORD_GAP:           kind_len = cfg.unit7;
			default:                 kind_len = {{(LEN_W-UNIT_W){1'b0}}, cfg.unit};
		endcase
	end

	assign slen_n = fetch ? kind_len : symbol_length_q;
	assign sc_inc = sample_count_q + LEN_W'(1);
	assign sc_n   = (sc_inc >= slen_n) ? '0 : sc_inc;
	assign key    = (kind_n == KIND_DIT) || (kind_n == KIND_DAH);

	// Linear ramp with saturation at full scale and at zero.
	assign env_sum = {1'b0, envelope_q} + {1'b0, cfg.ramp_step};
	always_comb begin
		if (key) begin
			env_n = env_sum[LVL_W] ? {LVL_W{1'b1}} : env_sum[LVL_W-1:0];
		end else if (envelope_q > cfg.ramp_step) begin
			env_n = envelope_q - cfg.ramp_step;
		end else begin
			env_n = '0;
		end
	end

	// The tone phase only runs while the envelope is open.
	assign ph_n = (env_n != '0) ? phase_q + cfg.phase_step : phase_q;

	// Keyer state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_pattern_q  <= '0;
			code_length_q   <= '0;
			symbol_index_q  <= '0;
			symbol_kind_q   <= KIND_IDLE;
			symbol_length_q <= LEN_W'(1);
			sample_count_q  <= '0;
			envelope_q      <= '0;
			phase_q         <= '0;
		end else if (tick) begin
			code_pattern_q  <= pat_n;
			code_length_q   <= len_n;
			symbol_index_q  <= idx_n;
			symbol_kind_q   <= kind_n;
			symbol_length_q <= slen_n;
			sample_count_q  <= sc_n;
			envelope_q      <= env_n;
			phase_q         <= ph_n;
		end
	end

	assign pop            = tick && pop_c;
	assign res.key_down   = key;
	assign res.envelope   = env_n;
	assign res.tone_phase = ph_n;
	assign res.char_start = cs;
	assign res.char_sent  = sent;
	assign res.idle_start = idle;
	assign res.dropped    = 1'b0;

endmodule

`default_nettype wire

// ===== rtl/core/morse_keyer_envelope_top.sv =====
// Morse keyer top level: each accepted request gives one result through a registered output stage.
// Throughput one request per cycle while in_stall is low; a two-entry output stage lets requests keep
// entering while a result waits, so stall rises only when both entries are full.
// The queue head is read ahead from the character memory through one registered read port.
// Asynchronous active-low reset empties the queue, loads the default timing and idles the keyer.
// Depends on mke_pkg, mke_queue and mke_keyer.
`timescale 1ns / 1ps
`default_nettype none

module morse_keyer_envelope_top (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire                        mode,
	input  wire  [7:0]                 char_code,
	output logic                       out_valid,
	input  wire                        out_stall,
	output logic                       key_down,
	output logic [15:0]                envelope,
	output logic [15:0]                tone_phase,
	output logic                       char_start,
	output logic [7:0]                 char_sent,
	output logic                       idle_start,
	output logic                       dropped,
	input  wire                        cfg_we,
	input  wire  [1:0]                 cfg_index,
	input  wire  [mke_pkg::CFG_W-1:0]  cfg_data
);
	import mke_pkg::*;

	cfg_t             cfg_q;
	logic             mute_q;
	logic [UNIT_W-1:0] cfg_unit;

	logic   acc_in;
	logic   tick_go;
	logic   push;
	logic   pop;
	qent_t  head;
	qstat_t qstat;
	res_t   kres;
	res_t   res;
	res_t   out_q;
	res_t   skid_q;
	logic   out_valid_q;
	logic   skid_valid_q;
	logic   out_fire;

	assign cfg_unit = cfg_data[UNIT_W-1:0];

	// Configuration registers; the unit multiples are formed as the unit is written.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unit       <= UNIT_RST;
			cfg_q.unit3      <= LEN_W'(3) * {{(LEN_W-UNIT_W){1'b0}}, UNIT_RST};
			cfg_q.unit7      <= LEN_W'(7) * {{(LEN_W-UNIT_W){1'b0}}, UNIT_RST};
			cfg_q.ramp_step  <= RAMP_RST;
			cfg_q.phase_step <= PHASE_RST;
			mute_q           <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_UNIT_SAMPLES: begin
					cfg_q.unit  <= cfg_unit;
					cfg_q.unit3 <= {3'b000, cfg_unit} + {2'b00, cfg_unit, 1'b0};
					cfg_q.unit7 <= {cfg_unit, 3'b000} - {3'b000, cfg_unit};
				end
				REG_RAMP_STEP:  cfg_q.ramp_step  <= cfg_data[LVL_W-1:0];
				REG_PHASE_STEP: cfg_q.phase_step <= cfg_data[LVL_W-1:0];
				REG_MUTE:       mute_q           <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign acc_in  = in_valid && !in_stall;
	assign push    = acc_in && !mode;
	assign tick_go = acc_in && mode && !mute_q;

	mke_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_char (char_code),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	mke_keyer u_keyer (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_go),
		.cfg    (cfg_q),
		.head   (head),
		.qstat  (qstat),
		.pop    (pop),
		.res    (kres)
	);

	// An enqueue reports only a drop; a muted tick reports zeros.
	always_comb begin
		res = '0;
		if (!mode) begin
			res.dropped = qstat.full;
		end else if (!mute_q) begin
			res = kres;
		end
	end

	// Output register with a skid entry behind it.
	assign out_fire = out_valid_q && !out_stall;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_fire) begin
			out_valid_q  <= skid_valid_q || acc_in;
			skid_valid_q <= 1'b0;
		end else if (acc_in) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_fire) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (acc_in) begin
			skid_q <= res;
		end
	end

	assign in_stall   = skid_valid_q;
	assign out_valid  = out_valid_q;
	assign key_down   = out_q.key_down;
	assign envelope   = out_q.envelope;
	assign tone_phase = out_q.tone_phase;
	assign char_start = out_q.char_start;
	assign char_sent  = out_q.char_sent;
	assign idle_start = out_q.idle_start;
	assign dropped    = out_q.dropped;

	// The skid entry is only ever filled behind a waiting result.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry holds a result while the output register is empty");

	// Every accepted request leaves a result waiting at the next edge.
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> out_valid_q)
		else $error("accepted request produced no result");

	// The keyer takes a character only from a queue that holds one.
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (qstat.nonempty && tick_go))
		else $error("queue popped while empty or outside a tick");

	// A character start and an idle start never come together.
	a_start_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |-> !(res.char_start && res.idle_start))
		else $error("character start and idle start in the same result");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the Morse keyer envelope top level.
// Sends character and sample-tick requests, predicts each result in a scoreboard class
// and checks every result as it leaves the block. Depends on mke_pkg and morse_keyer_envelope_top.
`timescale 1ns / 1ps

module tb;
	import mke_pkg::*;

	// Scoreboard: a cycle-free copy of the keyer that predicts one result per request.
	class keyer_tracker;
		// Copy of the configuration registers.
		bit [UNIT_W-1:0] unit_len;
		bit [15:0]       ramp;
		bit [15:0]       pstep;
		bit              muted;
		// Character queue.
		bit [7:0]        fifo_mem [QUEUE_DEPTH];
		int unsigned     rd_ptr, wr_ptr, fill;
		// Symbol sequencer, envelope and tone phase.
		bit [5:0]        dah_mask;
		int unsigned     n_elem, sym_idx;
		kind_t           kind;
		int unsigned     sym_len, smp_cnt, env, phase;
		// Results still to arrive, oldest first.
		res_t            due_outputs[$];
		int unsigned     mismatches;

		function new();
			unit_len = UNIT_RST;
			ramp = RAMP_RST;
			pstep = PHASE_RST;
			muted = 1'b0;
			rd_ptr = 0;
			wr_ptr = 0;
			fill = 0;
			dah_mask = '0;
			n_elem = 0;
			sym_idx = 0;
			kind = KIND_IDLE;
			sym_len = 1;
			smp_cnt = 0;
			env = 0;
			phase = 0;
			mismatches = 0;
		endfunction

		function void set_reg(reg_idx_t idx, bit [CFG_W-1:0] v);
			case (idx)
				REG_UNIT_SAMPLES: unit_len = v[UNIT_W-1:0];
				REG_RAMP_STEP:    ramp = v[15:0];
				REG_PHASE_STEP:   pstep = v[15:0];
				REG_MUTE:         muted = v[0];
				default: ;
			endcase
		endfunction

		// Element count and dah mask of a character; returns 0 when it has no code.
		function bit morse_lookup(bit [7:0] c, output bit [2:0] n, output bit [5:0] p);
			n = 3'd0;
			p = 6'h00;
			case (c)
				"A": {n, p} = {3'd2, 6'h02};
				"B": {n, p} = {3'd4, 6'h01};
				"C": {n, p} = {3'd4, 6'h05};
				"D": {n, p} = {3'd3, 6'h01};
				"E": {n, p} = {3'd1, 6'h00};
				"F": {n, p} = {3'd4, 6'h04};
				"G": {n, p} = {3'd3, 6'h03};
				"H": {n, p} = {3'd4, 6'h00};
				"I": {n, p} = {3'd2, 6'h00};
				"J": {n, p} = {3'd4, 6'h0E};
				"K": {n, p} = {3'd3, 6'h05};
				"L": {n, p} = {3'd4, 6'h02};
				"M": {n, p} = {3'd2, 6'h03};
				"N": {n, p} = {3'd2, 6'h01};
				"O": {n, p} = {3'd3, 6'h07};
				"P": {n, p} = {3'd4, 6'h06};
				"Q": {n, p} = {3'd4, 6'h0B};
				"R": {n, p} = {3'd3, 6'h02};
				"S": {n, p} = {3'd3, 6'h00};
				"T": {n, p} = {3'd1, 6'h01};
				"U": {n, p} = {3'd3, 6'h04};
				"V": {n, p} = {3'd4, 6'h08};
				"W": {n, p} = {3'd3, 6'h06};
				"X": {n, p} = {3'd4, 6'h09};
				"Y": {n, p} = {3'd4, 6'h0D};
				"Z": {n, p} = {3'd4, 6'h03};
				"0": {n, p} = {3'd5, 6'h1F};
				"1": {n, p} = {3'd5, 6'h1E};
				"2": {n, p} = {3'd5, 6'h1C};
				"3": {n, p} = {3'd5, 6'h18};
				"4": {n, p} = {3'd5, 6'h10};
				"5": {n, p} = {3'd5, 6'h00};
				"6": {n, p} = {3'd5, 6'h01};
				"7": {n, p} = {3'd5, 6'h03};
				"8": {n, p} = {3'd5, 6'h07};
				"9": {n, p} = {3'd5, 6'h0F};
				".": {n, p} = {3'd6, 6'h2A};
				",": {n, p} = {3'd6, 6'h33};
				"?": {n, p} = {3'd6, 6'h0C};
				"/": {n, p} = {3'd5, 6'h09};
				"=": {n, p} = {3'd5, 6'h11};
				"+": {n, p} = {3'd5, 6'h0A};
				"-": {n, p} = {3'd6, 6'h21};
				default: return 1'b0;
			endcase
			return 1'b1;
		endfunction

		// Odd positions are gaps, the last one closing the character; even ones are elements.
		function kind_t element_kind(int unsigned k);
			if (k[0]) begin
				return (k + 1 == 2 * n_elem) ? KIND_CHAR_GAP : KIND_ELEM_GAP;
			end
			return dah_mask[k >> 1] ? KIND_DAH : KIND_DIT;
		endfunction

		function int unsigned kind_len(kind_t kd);
			int unsigned n;
			if (kd == KIND_DAH || kd == KIND_CHAR_GAP) begin
				n = 3 * unit_len;
			end else if (kd == KIND_WORD_GAP) begin
				n = 7 * unit_len;
			end else begin
				n = unit_len;
			end
			return n & 32'h7F_FFFF;
		endfunction

		// Advance the copy by one accepted request and queue the result it causes.
		function void accept_request(bit m, bit [7:0] code);
			res_t     r;
			bit [7:0] c;
			bit [2:0] n;
			bit [5:0] p;
			bit       key;
			r = '0;
			if (!m) begin
				if (fill >= QUEUE_DEPTH) begin
					r.dropped = 1'b1;
				end else begin
					fifo_mem[wr_ptr] = code;
					wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
					fill++;
				end
				due_outputs.push_back(r);
				return;
			end
			// A muted tick freezes everything and reports zeros.
			if (muted) begin
				due_outputs.push_back(r);
				return;
			end
			// Fetch the next symbol once the current one has run out.
			if (smp_cnt == 0) begin
				if (sym_idx >= 2 * n_elem) begin
					n_elem = 0;
					dah_mask = '0;
					sym_idx = 0;
					kind = KIND_IDLE;
					if (fill > 0) begin
						c = fifo_mem[rd_ptr];
						rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
						fill--;
						if (c == CHAR_SPACE) begin
							kind = KIND_WORD_GAP;
							r.char_start = 1'b1;
							r.char_sent = c;
						end else begin
							if (c >= "a" && c <= "z") begin
								c = c - 8'h20;
							end
							// An unknown character plays one idle unit with no flags.
							if (morse_lookup(c, n, p)) begin
								n_elem = n;
								dah_mask = p;
								r.char_start = 1'b1;
								r.char_sent = c;
								kind = element_kind(0);
							end
						end
					end else begin
						r.idle_start = 1'b1;
					end
				end else begin
					kind = element_kind(sym_idx);
				end
				sym_len = kind_len(kind);
				sym_idx = (sym_idx + 1) & 15;
			end
			// A zero symbol length wraps straight back, so it behaves as one sample.
			smp_cnt = (smp_cnt + 1) & 32'h7F_FFFF;
			if (smp_cnt >= sym_len) begin
				smp_cnt = 0;
			end
			// Linear ramp with saturation at both ends; the tone runs while the envelope is up.
			key = (kind == KIND_DIT || kind == KIND_DAH);
			if (key) begin
				env = (env + ramp > 65535) ? 65535 : env + ramp;
			end else begin
				env = (env > ramp) ? env - ramp : 0;
			end
			if (env > 0) begin
				phase = (phase + pstep) & 16'hFFFF;
			end
			r.key_down = key;
			r.envelope = env[15:0];
			r.tone_phase = phase[15:0];
			due_outputs.push_back(r);
		endfunction

		// Compare one result from the block with the oldest prediction.
		function void check_result(res_t got);
			res_t want;
			bit   bad;
			if (due_outputs.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result with no request waiting: %p", $realtime, got);
				end
				return;
			end
			want = due_outputs.pop_front();
			bad = (got.key_down !== want.key_down) || (got.envelope !== want.envelope) ||
				(got.tone_phase !== want.tone_phase) || (got.char_start !== want.char_start) ||
				(got.char_sent !== want.char_sent) || (got.idle_start !== want.idle_start) ||
				(got.dropped !== want.dropped);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: key/env/phase/start/char/idle/drop expected %0d %0d %0d %0d %h %0d %0d",
						$realtime, want.key_down, want.envelope, want.tone_phase, want.char_start,
						want.char_sent, want.idle_start, want.dropped);
					$display("%0t: key/env/phase/start/char/idle/drop actual   %0d %0d %0d %0d %h %0d %0d",
						$realtime, got.key_down, got.envelope, got.tone_phase, got.char_start,
						got.char_sent, got.idle_start, got.dropped);
				end
			end
		endfunction

		// Anything still waiting at the end is a lost result.
		function void close();
			if (due_outputs.size() != 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0d results never arrived", due_outputs.size());
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               mode;
	logic [7:0]         char_code;
	logic               out_valid;
	logic               out_stall;
	logic               key_down;
	logic [15:0]        envelope;
	logic [15:0]        tone_phase;
	logic               char_start;
	logic [7:0]         char_sent;
	logic               idle_start;
	logic               dropped;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [CFG_W-1:0]   cfg_data;

	keyer_tracker tracker;
	bit           long_hold_req;
	string        morse_chars = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,?/=+-";

	morse_keyer_envelope_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.char_code  (char_code),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_down   (key_down),
		.envelope   (envelope),
		.tone_phase (tone_phase),
		.char_start (char_start),
		.char_sent  (char_sent),
		.idle_start (idle_start),
		.dropped    (dropped),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Clock, 2 ns period.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Safety net against a hung handshake.
	initial begin
		#2_000_000;
		$display("morse_keyer_envelope_top: mismatch");
		$finish;
	end

	// Check each result taken by the receiver.
	always @(posedge clk) begin : watch_results
		res_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.key_down = key_down;
			seen.envelope = envelope;
			seen.tone_phase = tone_phase;
			seen.char_start = char_start;
			seen.char_sent = char_sent;
			seen.idle_start = idle_start;
			seen.dropped = dropped;
			tracker.check_result(seen);
		end
	end

	// Receiver: short random stalls, calm stretches, and one long hold on request.
	initial begin : stall_driver
		int unsigned stall_left;
		int unsigned calm_left;
		bit          hold_done;
		stall_left = 0;
		calm_left = 0;
		hold_done = 1'b0;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (long_hold_req && !hold_done) begin
				hold_done = 1'b1;
				stall_left = 299;
				out_stall <= 1'b1;
			end else if (calm_left > 0) begin
				calm_left--;
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 199) == 0) begin
				calm_left = $urandom_range(50, 200);
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 99) < 20) begin
				stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2) : $urandom_range(10, 50);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic int unsigned sender_gap(bit calm);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (calm || r < 75) begin
			return 0;
		end
		return (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
	endfunction

	// Mostly characters with a code (letters in either case), some spaces, some raw bytes.
	function automatic bit [7:0] pick_char();
		int unsigned r;
		bit [7:0]    c;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			c = morse_chars[$urandom_range(0, morse_chars.len() - 1)];
			if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) begin
				c = c + 8'h20;
			end
			return c;
		end
		return (r < 75) ? CHAR_SPACE : 8'($urandom_range(0, 255));
	endfunction

	// Offer one request, hold it until accepted, then idle for the given gap.
	task automatic send_request(bit m, bit [7:0] c, int unsigned gap);
		in_valid <= 1'b1;
		mode <= m;
		char_code <= c;
		do @(posedge clk); while (in_stall);
		tracker.accept_request(m, c);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every predicted result has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		while (tracker.due_outputs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic put_reg(reg_idx_t idx, bit [CFG_W-1:0] v);
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		tracker.set_reg(idx, v);
	endtask

	task automatic program_regs(bit [CFG_W-1:0] u, bit [CFG_W-1:0] r, bit [CFG_W-1:0] p, bit mu);
		cfg_we <= 1'b1;
		put_reg(REG_UNIT_SAMPLES, u);
		put_reg(REG_RAMP_STEP, r);
		put_reg(REG_PHASE_STEP, p);
		put_reg(REG_MUTE, CFG_W'(mu));
		cfg_we <= 1'b0;
	endtask

	// One random phase: fresh settings, then a mix of characters, ticks and overflow bursts.
	task automatic random_phase(int unsigned ph, int unsigned n_items, bit last_phase);
		bit [CFG_W-1:0] u, r, p;
		int unsigned    enq_pct, pause_at, i, k, burst;
		bit             calm, paused, held;
		case ($urandom_range(0, 19))
			0:       u = 0;
			1, 2:    u = $urandom_range(13, 60);
			3, 4, 5: u = $urandom_range(4, 12);
			default: u = $urandom_range(1, 3);
		endcase
		// The longest unit would hold one symbol past the end, so it comes last.
		if (last_phase) begin
			u = 20'hF_FFFF;
		end
		case ($urandom_range(0, 9))
			0:       r = 0;
			1:       r = 1;
			2, 3:    r = 16'hFFFF;
			4, 5:    r = $urandom_range(1, 3000);
			default: r = $urandom_range(1, 65535);
		endcase
		case ($urandom_range(0, 9))
			0:       p = 0;
			1:       p = 16'hFFFF;
			default: p = $urandom_range(0, 65535);
		endcase
		program_regs(u, r, p, ($urandom_range(0, 9) == 0) && ph != 3);
		case ($urandom_range(0, 2))
			0:       enq_pct = 5;
			1:       enq_pct = 20;
			default: enq_pct = 40;
		endcase
		calm = ($urandom_range(0, 3) == 0);
		pause_at = (ph == 1 || $urandom_range(0, 2) == 0) ? $urandom_range(1, n_items - 1) : n_items;
		paused = 1'b0;
		held = 1'b0;
		i = 0;
		while (i < n_items) begin
			if ($urandom_range(0, 199) == 0) begin
				// Enough characters back to back to overflow the queue.
				burst = $urandom_range(66, 72);
				for (k = 0; k < burst; k++) begin
					send_request(1'b0, pick_char(), sender_gap(calm));
				end
				i += burst;
			end else if ($urandom_range(0, 99) < enq_pct) begin
				send_request(1'b0, pick_char(), sender_gap(calm));
				i++;
			end else begin
				send_request(1'b1, 8'($urandom_range(0, 255)), sender_gap(calm));
				i++;
			end
			if (ph == 3 && !held && i >= n_items / 2) begin
				held = 1'b1;
				long_hold_req = 1'b1;
			end
			if (!paused && i >= pause_at) begin
				paused = 1'b1;
				drain();
			end
		end
		drain();
	endtask

	// Main sequence: reset, directed requests, then random phases.
	initial begin : stimulus
		int unsigned ph;
		tracker = new();
		long_hold_req = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= 1'b0;
		char_code <= 8'h00;
		cfg_we <= 1'b0;
		cfg_index <= REG_UNIT_SAMPLES;
		cfg_data <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero unit length and zero ramp: one-sample symbols, envelope held at zero.
		program_regs(0, 0, 16'hFFFF, 1'b0);
		send_request(1'b0, "E", sender_gap(1'b0));
		send_request(1'b0, "a", sender_gap(1'b0));
		send_request(1'b0, CHAR_SPACE, sender_gap(1'b0));
		send_request(1'b0, 8'h00, sender_gap(1'b0));
		send_request(1'b0, 8'hFF, sender_gap(1'b0));
		repeat (10) send_request(1'b1, 8'($urandom_range(0, 255)), sender_gap(1'b0));
		drain();

		// Muted: a character still enters the queue, ticks give zeros.
		program_regs(1, 16'hFFFF, 0, 1'b1);
		send_request(1'b0, "?", sender_gap(1'b0));
		repeat (2) send_request(1'b1, 8'($urandom_range(0, 255)), sender_gap(1'b0));
		drain();

		// Unmuted with the steepest ramp: the queued character starts to play.
		program_regs(1, 16'hFFFF, 12345, 1'b0);
		repeat (8) send_request(1'b1, 8'($urandom_range(0, 255)), sender_gap(1'b0));
		drain();

		for (ph = 0; ph < 12; ph++) begin
			random_phase(ph, 140, ph == 11);
		end

		repeat (8) @(posedge clk);
		tracker.close();
		if (tracker.mismatches == 0) begin
			$display("morse_keyer_envelope_top: match");
		end else begin
			$display("morse_keyer_envelope_top: mismatch");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/mke_pkg.sv
rtl/core/mke_queue.sv
rtl/core/mke_keyer.sv
rtl/core/morse_keyer_envelope_top.sv
bench/tb.sv
